/* hdl/sync_crlf_frame_receiver_macros.svh */
// Assertion macros used by the checker file of the frame receiver.
// No dependencies; include by bare file name.
`ifndef SYNC_CRLF_FRAME_RECEIVER_MACROS_SVH
`define SYNC_CRLF_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

/* hdl/sfr_pkg.sv */
// Types, codes and constants of the CR-LF frame receiver.
// No dependencies; used by every module of the block.
package sfr_pkg;

  localparam int SLOTS        = 8;
  localparam int SLOT_W       = 3;
  localparam int HEADER_BYTES = 12;
  localparam int CNT_W        = 6;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] RST_SYNC_FIRST  = 8'h04;
  localparam logic [7:0] RST_SYNC_SECOND = 8'h93;
  localparam logic [5:0] RST_MIN_LEN     = 6'd17;
  localparam logic [5:0] RST_MAX_COUNT   = 6'd48;

  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    ST_HUNT     = 3'd0,
    ST_BYTE     = 3'd1,
    ST_OK       = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LEN_ERR  = 3'd4,
    ST_SUM_ERR  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 3'd0,
    REG_SYNC_SECOND = 3'd1,
    REG_MIN_LEN     = 3'd2,
    REG_MAX_COUNT   = 3'd3,
    REG_CHECK_EN    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [5:0] min_frame_len;
    logic [5:0] max_count;
    logic       check_enable;
  } cfg_t;

  typedef struct packed {
    logic             in_frame;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       length_high;
    logic [7:0]       length_low;
    logic [7:0]       running_xor;
    logic [2:0][7:0]  delayed_bytes;  // [0] newest
    logic [SLOT_W-1:0] slot_pointer;
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        byte_out;
    logic [5:0]        byte_position;
    logic [5:0]        frame_size;
    logic [15:0]       payload_length;
    logic [SLOT_W-1:0] slot_index;
  } result_t;

endpackage

/* hdl/sfr_step.sv */
// Per-byte next-state and result logic of the CR-LF frame receiver.
// Depends on sfr_pkg.
module sfr_step (
  input  sfr_pkg::cfg_t    cfg,
  input  sfr_pkg::state_t  cur,
  input  logic [7:0]       data_byte,
  output sfr_pkg::state_t  nxt,
  output sfr_pkg::result_t res
);

  always_comb begin
    logic        crlf;
    logic [5:0]  cnt_inc;
    logic [7:0]  xr;
    logic [7:0]  body;
    logic [16:0] len;
    logic [16:0] want;

    nxt = cur;
    res.status         = sfr_pkg::ST_HUNT;
    res.byte_out       = data_byte;
    res.byte_position  = '0;
    res.frame_size     = '0;
    res.payload_length = '0;
    res.slot_index     = cur.slot_pointer;

    crlf    = (data_byte == sfr_pkg::CHAR_LF) && (cur.delayed_bytes[0] == sfr_pkg::CHAR_CR);
    cnt_inc = cur.byte_count + 6'd1;
    xr      = cur.running_xor;
    body    = '0;
    len     = '0;
    want    = '0;

    if (!cur.in_frame) begin
      priority if (data_byte == cfg.sync_first && cur.byte_count == 6'd0) begin
        nxt.byte_count = 6'd1;
      end else if (data_byte == cfg.sync_second && cur.byte_count == 6'd1) begin
        nxt.byte_count    = 6'd2;
        nxt.in_frame      = 1'b1;
        nxt.length_high   = '0;
        nxt.length_low    = '0;
        nxt.running_xor   = '0;
        res.byte_position = 6'd1;
        res.status        = sfr_pkg::ST_BYTE;
      end else if (data_byte == cfg.sync_first && cur.byte_count == 6'd1) begin
        nxt.byte_count = cur.byte_count;
      end else begin
        nxt.byte_count = '0;
      end
      nxt.delayed_bytes = {cur.delayed_bytes[1:0], data_byte};
    end else if (cur.byte_count > cfg.max_count || cur.byte_count == 6'd63) begin
      res.status        = sfr_pkg::ST_OVERFLOW;
      res.byte_position = cur.byte_count;
      nxt.in_frame      = 1'b0;
      nxt.byte_count    = '0;
    end else begin
      res.byte_position = cur.byte_count;
      res.status        = sfr_pkg::ST_BYTE;
      nxt.byte_count    = cnt_inc;
      if (cur.byte_count == 6'd10) nxt.length_high = data_byte;
      if (cur.byte_count == 6'd11) nxt.length_low  = data_byte;
      if (cur.byte_count >= 6'(sfr_pkg::HEADER_BYTES)) xr = cur.running_xor ^ data_byte;
      nxt.running_xor   = xr;
      nxt.delayed_bytes = {cur.delayed_bytes[1:0], data_byte};

      len  = {1'b0, nxt.length_high, nxt.length_low};
      want = len + 17'(sfr_pkg::HEADER_BYTES + 2);
      // body XOR excludes the checksum byte and the trailing CR LF
      body = xr ^ data_byte ^ cur.delayed_bytes[0] ^ cur.delayed_bytes[1];

      if (crlf && cnt_inc >= cfg.min_frame_len) begin
        res.frame_size     = cnt_inc;
        res.payload_length = len[15:0];
        res.status         = sfr_pkg::ST_OK;
        if (cfg.check_enable) begin
          if (len == 17'd0 || {11'd0, cnt_inc} != want) begin
            res.status = sfr_pkg::ST_LEN_ERR;
          end else if (body != cur.delayed_bytes[1]) begin
            res.status = sfr_pkg::ST_SUM_ERR;
          end
        end
        nxt.in_frame   = 1'b0;
        nxt.byte_count = '0;
        nxt.slot_pointer = (cur.slot_pointer == sfr_pkg::SLOT_W'(sfr_pkg::SLOTS - 1))
                         ? '0 : cur.slot_pointer + 1'b1;
      end
    end
  end

endmodule

/* hdl/sync_crlf_frame_receiver.sv */
// Top level of the CR-LF frame receiver: stream ports, config registers,
// frame state and the result register. Depends on sfr_pkg and sfr_step.
//
// Takes one byte per request and returns one result per byte. A byte is
// accepted every cycle while the result register is empty or being drained;
// the result shows in the cycle after acceptance. The whole per-byte
// decision (sync hunt, count, CR LF end, length and XOR checks) sits in one
// combinational step between the frame state and the result register.
module sync_crlf_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_out[7:0], byte_position[13:8], frame_size[19:14],
  // payload_length[35:20], slot_index[38:36], zero[39]
  output logic [sfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  sfr_pkg::cfg_t    cfg;
  sfr_pkg::state_t  st;
  sfr_pkg::state_t  st_next;
  sfr_pkg::result_t res_next;
  sfr_pkg::result_t res;
  logic             accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfr_step u_step (
    .cfg       (cfg),
    .cur       (st),
    .data_byte (s_axis_tdata),
    .nxt       (st_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= sfr_pkg::RST_SYNC_FIRST;
      cfg.sync_second   <= sfr_pkg::RST_SYNC_SECOND;
      cfg.min_frame_len <= sfr_pkg::RST_MIN_LEN;
      cfg.max_count     <= sfr_pkg::RST_MAX_COUNT;
      cfg.check_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sfr_pkg::reg_idx_t'(cfg_index))
        sfr_pkg::REG_SYNC_FIRST:  cfg.sync_first    <= cfg_data;
        sfr_pkg::REG_SYNC_SECOND: cfg.sync_second   <= cfg_data;
        sfr_pkg::REG_MIN_LEN:     cfg.min_frame_len <= cfg_data[5:0];
        sfr_pkg::REG_MAX_COUNT:   cfg.max_count     <= cfg_data[5:0];
        sfr_pkg::REG_CHECK_EN:    cfg.check_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      st            <= st_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {1'b0, res.slot_index, res.payload_length, res.frame_size,
                         res.byte_position, res.byte_out};

endmodule

/* hdl/sfr_checker.sv */
// Port-level checks of the CR-LF frame receiver, bound to the top level.
// Depends on sfr_pkg and sync_crlf_frame_receiver_macros.svh.
`include "sync_crlf_frame_receiver_macros.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [sfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic hunt;
  logic in_byte;
  logic ok;

  assign hunt    = m_axis_tvalid && m_axis_tuser == sfr_pkg::ST_HUNT;
  assign in_byte = m_axis_tvalid && m_axis_tuser == sfr_pkg::ST_BYTE;
  assign ok      = m_axis_tvalid && m_axis_tuser == sfr_pkg::ST_OK;

  `SFR_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `SFR_ASSERT_NOW(a_hunt_zero, clk, rst, hunt, m_axis_tdata[35:8] == 28'd0)
  `SFR_ASSERT_NOW(a_byte_no_end, clk, rst, in_byte, m_axis_tdata[35:14] == 22'd0)
  `SFR_ASSERT_NOW(a_ok_sized, clk, rst, ok, m_axis_tdata[19:14] != 6'd0)

endmodule

bind sync_crlf_frame_receiver sfr_checker u_sfr_checker (.*);
